@@ rtl/giir_pkg.sv @@
package giir_pkg;

    localparam int ACC_BITS       = 64;
    localparam int NORM_SHIFT     = 20;
    localparam int CFG_BITS       = 5;
    localparam int CFG_INDEX_BITS = 1;
    localparam int TAP_INDEX_BITS = 4;
    localparam int MODE_BITS      = 2;

    typedef logic [MODE_BITS-1:0]      t_mode;
    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;

    localparam t_mode MODE_SAMPLE = 2'd0;
    localparam t_mode MODE_NUM    = 2'd1;
    localparam t_mode MODE_DEN    = 2'd2;

    localparam t_cfg_index REG_NUM_TAPS = 1'd0;
    localparam t_cfg_index REG_DEN_TAPS = 1'd1;

endpackage

@@ rtl/giir_in_if.sv @@
interface giir_in_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEFF_BITS  = 24
);
    import giir_pkg::*;

    logic                          valid;
    logic                          ready;
    t_mode                         mode;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [COEFF_BITS-1:0]  tap_value;

    modport source (output valid, mode, sample_in, tap_index, tap_value, input ready);
    modport sink   (input valid, mode, sample_in, tap_index, tap_value, output ready);

endinterface

@@ rtl/giir_out_if.sv @@
interface giir_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered_sample;
    logic                          saturated;

    modport source (output valid, filtered_sample, saturated, input ready);
    modport sink   (input valid, filtered_sample, saturated, output ready);

endinterface

@@ rtl/general_iir_filter_top.sv @@
// Direct-form I IIR filter, fixed point (samples Q1.15, taps Q4.20).
// Input channel i_in carries requests: mode 0 filters sample_in, mode 1 or 2
// writes tap_value into numerator or denominator tap tap_index, mode 3 is
// dropped. Only sample requests produce a request on o_out.
// Tap counts are set through the write port i_cfg_we / i_cfg_index /
// i_cfg_data. The user must write them only while the filter is idle;
// the block itself does not enforce this.
// A sample runs through the single multiply-accumulate, fed one tap per
// cycle from the tap and history memories, over N taps, where N is the
// number of active numerator taps plus active denominator taps past tap 0.
// When denominator tap 0 is nonzero, the one-bit-per-cycle divider then
// divides by it as normalizer. i_in is taken one request at a time.
// Reset sets both tap counts to 1 and makes all taps and history read zero.
// If the receiver stalls, the finished result waits in the output register
// and the next request is still accepted; its result is held back until
// the output register frees up.
module general_iir_filter_top #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int COEFF_BITS  = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    giir_in_if.sink                          i_in,
    giir_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  giir_pkg::t_cfg_index             i_cfg_index,
    input  logic [giir_pkg::CFG_BITS-1:0]    i_cfg_data
);
    import giir_pkg::*;

    localparam int CA = $clog2(2 * MAX_TAPS);
    localparam int PW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int PB = SAMPLE_BITS + COEFF_BITS;

    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        $signed({{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(MAX_TAPS - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(MAX_TAPS - 1) : p - PW'(1);
    endfunction

    function automatic logic [CW-1:0] clamp_taps(input logic [CFG_BITS-1:0] n);
        return (int'(n) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(n);
    endfunction

    logic [2:0]                    r_state, n_state;
    logic [CFG_BITS-1:0]           r_num, r_den;
    logic [PW-1:0]                 r_xwp, r_ywp, r_rp, r_ck;
    logic [CW-1:0]                 r_ff_left, r_fb_left;
    logic                          r_t1_valid, r_t1_fb, r_t1_norm;
    logic                          r_t2_valid, r_t2_fb;
    logic signed [PB-1:0]          r_prod;
    logic signed [COEFF_BITS-1:0]  r_norm;
    logic signed [ACC_BITS-1:0]    r_acc, r_y;
    logic                          r_out_valid, r_out_sat;
    logic [SAMPLE_BITS-1:0]        r_out_sample;

    logic                          in_acc, is_sample, tap_ok;
    logic [CW-1:0]                 nff, nden, nfb;
    logic [PW-1:0]                 xwp_new, ywp_new;
    logic                          iss_ff, iss_fb, issue_last, drained;
    logic                          coef_we, hist_we;
    logic [CA-1:0]                 coef_waddr, coef_raddr, hist_waddr, hist_raddr;
    logic [COEFF_BITS-1:0]         coef_rdata;
    logic [SAMPLE_BITS-1:0]        hist_wdata, hist_rdata, y_sat;
    logic                          sat_hi, sat_lo, out_load;
    logic                          div_start, div_done;
    logic [ACC_BITS-1:0]           div_quot;

    assign in_acc    = i_in.valid && i_in.ready;
    assign is_sample = in_acc && (i_in.mode == MODE_SAMPLE);
    assign tap_ok    = int'(i_in.tap_index) < MAX_TAPS;

    assign nff     = clamp_taps(r_num);
    assign nden    = clamp_taps(r_den);
    assign nfb     = (nden != '0) ? nden - CW'(1) : '0;
    assign xwp_new = ptr_inc(r_xwp);
    assign ywp_new = ptr_inc(r_ywp);

    assign iss_ff  = (r_state == ST_ISSUE) && (r_ff_left != '0);
    assign iss_fb  = (r_state == ST_ISSUE) && (r_ff_left == '0) && (r_fb_left != '0);
    assign issue_last = (!iss_ff && !iss_fb)
                     || (iss_ff && r_ff_left == CW'(1) && r_fb_left == '0)
                     || (iss_fb && r_fb_left == CW'(1));
    assign drained = !r_t1_valid && !r_t2_valid && !r_t1_norm;

    // normalizer tap is read while idle; taps one per cycle during issue
    assign coef_raddr = iss_ff ? CA'(r_ck)
                      : iss_fb ? CA'(MAX_TAPS) + CA'(r_ck)
                      : CA'(MAX_TAPS);
    assign hist_raddr = iss_fb ? CA'(MAX_TAPS) + CA'(r_rp) : CA'(r_rp);

    always_comb begin
        coef_we    = 1'b0;
        coef_waddr = CA'(i_in.tap_index);
        if (in_acc) begin
            unique case (i_in.mode)
                MODE_NUM: begin
                    coef_we = tap_ok;
                end
                MODE_DEN: begin
                    coef_we    = tap_ok;
                    coef_waddr = CA'(MAX_TAPS) + CA'(i_in.tap_index);
                end
                default: begin
                    coef_we = 1'b0;
                end
            endcase
        end
    end

    assign sat_hi   = r_y > SAT_HI;
    assign sat_lo   = r_y < SAT_LO;
    assign y_sat    = sat_hi ? SAT_HI[SAMPLE_BITS-1:0]
                    : sat_lo ? SAT_LO[SAMPLE_BITS-1:0]
                    : r_y[SAMPLE_BITS-1:0];
    assign out_load = (r_state == ST_SAT) && (!r_out_valid || o_out.ready);

    assign hist_we    = is_sample || out_load;
    assign hist_waddr = is_sample ? CA'(xwp_new) : CA'(MAX_TAPS) + CA'(ywp_new);
    assign hist_wdata = is_sample ? i_in.sample_in : y_sat;

    assign div_start = (r_state == ST_DRAIN) && drained && (r_norm != '0);

    giir_ram #(
        .DEPTH (2 * MAX_TAPS),
        .WIDTH (COEFF_BITS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_in.tap_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    giir_ram #(
        .DEPTH (2 * MAX_TAPS),
        .WIDTH (SAMPLE_BITS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    giir_div #(
        .DIVIDEND_BITS (ACC_BITS),
        .DIVISOR_BITS  (COEFF_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_norm),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (is_sample) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (issue_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (drained) n_state = (r_norm != '0) ? ST_DIV : ST_SAT;
            end
            ST_DIV: begin
                if (div_done) n_state = ST_SAT;
            end
            ST_SAT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num       <= CFG_BITS'(1);
            r_den       <= CFG_BITS'(1);
            r_xwp       <= '0;
            r_ywp       <= '0;
            r_rp        <= '0;
            r_ck        <= '0;
            r_ff_left   <= '0;
            r_fb_left   <= '0;
            r_t1_valid  <= 1'b0;
            r_t1_fb     <= 1'b0;
            r_t1_norm   <= 1'b0;
            r_t2_valid  <= 1'b0;
            r_t2_fb     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_NUM_TAPS: r_num <= i_cfg_data;
                    REG_DEN_TAPS: r_den <= i_cfg_data;
                    default: ;
                endcase
            end

            if (is_sample) begin
                r_xwp     <= xwp_new;
                r_ff_left <= nff;
                r_fb_left <= nfb;
                if (nff == '0) begin
                    r_ck <= PW'(1);
                    r_rp <= r_ywp;
                end else begin
                    r_ck <= '0;
                    r_rp <= xwp_new;
                end
            end else if (iss_ff) begin
                r_ff_left <= r_ff_left - CW'(1);
                if (r_ff_left == CW'(1)) begin
                    r_ck <= PW'(1);
                    r_rp <= r_ywp;
                end else begin
                    r_ck <= r_ck + PW'(1);
                    r_rp <= ptr_dec(r_rp);
                end
            end else if (iss_fb) begin
                r_fb_left <= r_fb_left - CW'(1);
                r_ck      <= r_ck + PW'(1);
                r_rp      <= ptr_dec(r_rp);
            end

            r_t1_valid <= iss_ff || iss_fb;
            r_t1_fb    <= iss_fb;
            r_t1_norm  <= is_sample;
            r_t2_valid <= r_t1_valid;
            r_t2_fb    <= r_t1_fb;

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_ywp       <= ywp_new;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_t1_norm) begin
            r_norm <= $signed(coef_rdata);
        end
        if (r_t1_valid) begin
            r_prod <= $signed(coef_rdata) * $signed(hist_rdata);
        end
        if (is_sample) begin
            r_acc <= '0;
        end else if (r_t2_valid) begin
            r_acc <= r_t2_fb ? r_acc - ACC_BITS'(r_prod) : r_acc + ACC_BITS'(r_prod);
        end
        if ((r_state == ST_DRAIN) && drained && (r_norm == '0)) begin
            r_y <= r_acc >>> NORM_SHIFT;
        end else if (div_done) begin
            r_y <= $signed(div_quot);
        end
        if (out_load) begin
            r_out_sample <= y_sat;
            r_out_sat    <= sat_hi || sat_lo;
        end
    end

    assign i_in.ready            = (r_state == ST_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.filtered_sample = r_out_sample;
    assign o_out.saturated       = r_out_sat;

endmodule

@@ rtl/giir_ram.sv @@
module giir_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

@@ rtl/giir_div.sv @@
module giir_div #(
    parameter int DIVIDEND_BITS = 64,
    parameter int DIVISOR_BITS  = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [DIVIDEND_BITS-1:0] i_dividend,
    input  logic signed [DIVISOR_BITS-1:0]  i_divisor,
    output logic                            o_done,
    output logic [DIVIDEND_BITS-1:0]        o_quot
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [DIVIDEND_BITS-1:0] r_q;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVISOR_BITS-1:0]  r_dv;
    logic                     r_neg;
    logic [DIVISOR_BITS:0]    trial;

    assign trial = {r_rem, r_q[DIVIDEND_BITS-1]} - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DIVIDEND_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // unsigned restoring divide on magnitudes, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[DIVIDEND_BITS-1] ? 0 - i_dividend : i_dividend;
            r_dv  <= i_divisor[DIVISOR_BITS-1] ? -i_divisor : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[DIVIDEND_BITS-1] ^ i_divisor[DIVISOR_BITS-1];
        end else if (r_busy) begin
            if (!trial[DIVISOR_BITS]) begin
                r_rem <= trial[DIVISOR_BITS-1:0];
                r_q   <= {r_q[DIVIDEND_BITS-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DIVISOR_BITS-2:0], r_q[DIVIDEND_BITS-1]};
                r_q   <= {r_q[DIVIDEND_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? 0 - r_q : r_q;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import giir_pkg::*;

    localparam int MAX_TAPS       = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEFF_BITS     = 24;
    localparam int SETTLE_CYCLES  = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_PHASES       = 8;
    localparam int PHASE_REQUESTS = 80;

    localparam t_mode MODE_IGNORED = 2'd3;

    localparam logic signed [COEFF_BITS-1:0]  COEFF_MAX = 24'h7FFFFF;
    localparam logic signed [COEFF_BITS-1:0]  COEFF_MIN = 24'h800000;
    localparam logic signed [COEFF_BITS-1:0]  UNITY     = 24'h100000;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX   = 16'h7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN   = 16'h8000;
    localparam longint                        OUT_HI    = 32767;
    localparam longint                        OUT_LO    = -32768;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] filtered_sample;
        logic                          saturated;
    } t_filter_result;

    class filter_scoreboard;
        logic [CFG_BITS-1:0]           ff_taps;
        logic [CFG_BITS-1:0]           fb_taps;
        logic signed [COEFF_BITS-1:0]  ff_coeff [MAX_TAPS];
        logic signed [COEFF_BITS-1:0]  fb_coeff [MAX_TAPS];
        logic signed [SAMPLE_BITS-1:0] x_hist [MAX_TAPS];
        logic signed [SAMPLE_BITS-1:0] y_hist [MAX_TAPS];
        t_filter_result                expected_outputs [$];
        int                            errors;

        function new();
            ff_taps = 5'd1;
            fb_taps = 5'd1;
            errors  = 0;
            for (int i = 0; i < MAX_TAPS; i++) begin
                ff_coeff[i] = '0;
                fb_coeff[i] = '0;
                x_hist[i]   = '0;
                y_hist[i]   = '0;
            end
        endfunction

        function void set_reg(t_cfg_index idx, logic [CFG_BITS-1:0] value);
            if (idx == REG_NUM_TAPS) begin
                ff_taps = value;
            end else begin
                fb_taps = value;
            end
        endfunction

        function void note_request(t_mode mode, logic signed [SAMPLE_BITS-1:0] smp,
                                   logic [TAP_INDEX_BITS-1:0] idx,
                                   logic signed [COEFF_BITS-1:0] coeff);
            int             i;
            int             n_ff;
            int             n_fb;
            longint         acc;
            longint         norm;
            longint         quo;
            t_filter_result res;
            if (mode == MODE_NUM) begin
                ff_coeff[idx] = coeff;
                return;
            end
            if (mode == MODE_DEN) begin
                fb_coeff[idx] = coeff;
                return;
            end
            if (mode != MODE_SAMPLE) return;

            for (i = MAX_TAPS - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
            x_hist[0] = smp;
            n_ff = (ff_taps > MAX_TAPS) ? MAX_TAPS : int'(ff_taps);
            n_fb = (fb_taps > MAX_TAPS) ? MAX_TAPS : int'(fb_taps);

            acc = 0;
            for (i = 0; i < n_ff; i++) acc += longint'(ff_coeff[i]) * longint'(x_hist[i]);
            for (i = 1; i < n_fb; i++) acc -= longint'(fb_coeff[i]) * longint'(y_hist[i-1]);

            norm = fb_coeff[0];
            if (norm == 0) begin
                quo = acc >>> NORM_SHIFT;
            end else if (norm == -1) begin
                quo = -acc;
            end else begin
                quo = acc / norm;
            end

            res.saturated = 1'b1;
            if (quo > OUT_HI) begin
                quo = OUT_HI;
            end else if (quo < OUT_LO) begin
                quo = OUT_LO;
            end else begin
                res.saturated = 1'b0;
            end
            res.filtered_sample = quo[SAMPLE_BITS-1:0];

            for (i = MAX_TAPS - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
            y_hist[0] = res.filtered_sample;
            expected_outputs.push_back(res);
        endfunction

        function void check_output(logic signed [SAMPLE_BITS-1:0] got_sample, logic got_sat);
            t_filter_result want;
            if (expected_outputs.size() == 0) begin
                $error("unexpected output: filtered_sample %0d saturated %0b",
                       got_sample, got_sat);
                errors++;
                return;
            end
            want = expected_outputs.pop_front();
            if (got_sample !== want.filtered_sample) begin
                $error("filtered_sample: expected %0d, actual %0d",
                       want.filtered_sample, got_sample);
                errors++;
            end
            if (got_sat !== want.saturated) begin
                $error("saturated: expected %0b, actual %0b", want.saturated, got_sat);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_index            i_cfg_index;
    logic [CFG_BITS-1:0]   i_cfg_data;

    giir_in_if  #(.SAMPLE_BITS(SAMPLE_BITS), .COEFF_BITS(COEFF_BITS)) in_if ();
    giir_out_if #(.SAMPLE_BITS(SAMPLE_BITS))                          out_if ();

    general_iir_filter_top #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    filter_scoreboard sb = new();
    int               src_idle_pct   = 0;
    int               sink_stall_pct = 0;
    int               stuck_cycles   = 0;

    int phase_ff [N_PHASES] = '{16, 0, 31, 4, 16, 1, 9, 0};
    int phase_fb [N_PHASES] = '{16, 0, 31, 3, 1, 17, 9, 2};
    int idle_src [4]        = '{0, 72, 0, 38};
    int idle_sink [4]       = '{0, 0, 72, 38};

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                sb.check_output(out_if.filtered_sample, out_if.saturated);
            end
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("general_iir_filter_top verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic signed [COEFF_BITS-1:0] rand_coeff();
        int v;
        v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        case ($urandom_range(7))
            0:       return COEFF_MAX;
            1:       return COEFF_MIN;
            2:       return '0;
            3, 4:    return 24'(v);
            default: return 24'($urandom());
        endcase
    endfunction

    // normalizer choices: none, unity, minus one, tiny divisor, near unity, anything
    function automatic logic signed [COEFF_BITS-1:0] rand_norm();
        int v;
        v = (1 << 20) + int'($urandom_range(0, 1 << 20)) - (1 << 19);
        case ($urandom_range(5))
            0:       return '0;
            1:       return UNITY;
            2:       return '1;
            3:       return 24'($urandom_range(1, 64));
            4:       return 24'(v);
            default: return rand_coeff();
        endcase
    endfunction

    task automatic push(t_mode mode, logic signed [SAMPLE_BITS-1:0] smp,
                        logic [TAP_INDEX_BITS-1:0] idx, logic signed [COEFF_BITS-1:0] coeff);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.mode      <= mode;
        in_if.sample_in <= smp;
        in_if.tap_index <= idx;
        in_if.tap_value <= coeff;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(mode, smp, idx, coeff);
    endtask

    task automatic wait_filter_idle();
        in_if.valid <= 1'b0;
        while (sb.expected_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tap_counts(logic [CFG_BITS-1:0] n_ff, logic [CFG_BITS-1:0] n_fb);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_NUM_TAPS;
        i_cfg_data  <= n_ff;
        @(posedge i_clk);
        sb.set_reg(REG_NUM_TAPS, n_ff);
        i_cfg_index <= REG_DEN_TAPS;
        i_cfg_data  <= n_fb;
        @(posedge i_clk);
        sb.set_reg(REG_DEN_TAPS, n_fb);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int p;
        int counted;
        int pick;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_NUM_TAPS;
        i_cfg_data      = '0;
        in_if.valid     = 1'b0;
        in_if.mode      = MODE_SAMPLE;
        in_if.sample_in = '0;
        in_if.tap_index = '0;
        in_if.tap_value = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, tap counts at reset value
        push(MODE_IGNORED, 16'hFFFF, 4'd15, 24'hFFFFFF);
        push(MODE_SAMPLE, SMP_MAX, 4'd0, '0);
        push(MODE_NUM, '0, 4'd0, COEFF_MAX);
        push(MODE_SAMPLE, SMP_MAX, 4'd0, '0);
        push(MODE_SAMPLE, SMP_MIN, 4'd0, '0);
        push(MODE_NUM, '0, 4'd0, COEFF_MIN);
        push(MODE_SAMPLE, SMP_MIN, 4'd0, '0);
        push(MODE_SAMPLE, 16'sd1, 4'd0, '0);
        push(MODE_NUM, '0, 4'd0, UNITY);
        push(MODE_SAMPLE, -16'sd1, 4'd0, '0);
        push(MODE_SAMPLE, 16'sd12345, 4'd0, '0);
        push(MODE_NUM, '0, 4'd0, 24'sd1);
        push(MODE_SAMPLE, -16'sd3, 4'd0, '0);
        push(MODE_SAMPLE, 16'sd3, 4'd0, '0);
        push(MODE_DEN, '0, 4'd0, '1);
        push(MODE_SAMPLE, 16'sd5, 4'd0, '0);
        push(MODE_DEN, '0, 4'd0, 24'sd3);
        push(MODE_SAMPLE, -16'sd7, 4'd0, '0);
        push(MODE_DEN, '0, 4'd0, COEFF_MIN);
        push(MODE_SAMPLE, SMP_MAX, 4'd0, '0);
        push(MODE_NUM, '0, 4'd15, COEFF_MAX);
        push(MODE_DEN, '0, 4'd15, COEFF_MIN);
        push(MODE_DEN, '0, 4'd1, COEFF_MAX);
        push(MODE_DEN, '0, 4'd0, '0);
        push(MODE_SAMPLE, SMP_MIN, 4'd0, '0);

        for (p = 0; p < N_PHASES; p++) begin
            wait_filter_idle();
            write_tap_counts(CFG_BITS'(phase_ff[p]), CFG_BITS'(phase_fb[p]));
            src_idle_pct   = idle_src[p % 4];
            sink_stall_pct = idle_sink[p % 4];
            counted = 0;
            while (counted < PHASE_REQUESTS) begin
                pick = $urandom_range(99);
                if (pick < 4) begin
                    push(MODE_IGNORED, rand_sample(), 4'($urandom()), rand_coeff());
                end else begin
                    counted++;
                    if (pick < 14) begin
                        push(MODE_NUM, rand_sample(), 4'($urandom()), rand_coeff());
                    end else if (pick < 20) begin
                        push(MODE_DEN, rand_sample(), 4'($urandom()), rand_coeff());
                    end else if (pick < 23) begin
                        push(MODE_DEN, rand_sample(), 4'd0, rand_norm());
                    end else begin
                        push(MODE_SAMPLE, rand_sample(), 4'($urandom()), rand_coeff());
                    end
                    if (p == 2 && counted == PHASE_REQUESTS / 2) wait_filter_idle();
                end
            end
        end

        wait_filter_idle();
        if (sb.errors == 0) begin
            $display("general_iir_filter_top verification clean");
        end else begin
            $display("general_iir_filter_top verification failed");
        end
        $finish;
    end

endmodule
